// ===== hw/rtl/frame_mean_squared_error_top_assert.svh =====
// assertion macros shared by the frame mse checker
// no dependencies; included by fmse_checker.sv
`ifndef FRAME_MEAN_SQUARED_ERROR_TOP_ASSERT_SVH
`define FRAME_MEAN_SQUARED_ERROR_TOP_ASSERT_SVH

// same-cycle implication
`define FMSE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fmse assertion failed");

// next-cycle implication
`define FMSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fmse assertion failed");

`endif

// ===== hw/rtl/fmse_pkg.sv =====
// constants, payload types and sequencer states for the frame mse block
// no dependencies
`default_nettype none

package fmse_pkg;

   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned SAMPLE_BITS = 16;
   localparam int unsigned MAX_PIXELS  = 1048576;
   localparam int unsigned SUM_W       = 56;
   localparam int unsigned COUNT_W     = 21;
   localparam int unsigned DIV_W       = COUNT_W + 1;
   localparam int unsigned MSE_W       = 32;
   localparam int unsigned PROD_W      = 2 * SAMPLE_W;
   localparam int unsigned STEP_W      = $clog2(SUM_W);

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
   localparam logic [COUNT_W-1:0]  MAX_COUNT   = COUNT_W'(MAX_PIXELS);
   localparam logic [STEP_W-1:0]   LAST_STEP   = STEP_W'(SUM_W - 1);

   // channel select codes for the square unit
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;
   localparam logic [1:0] CH_DRAIN = 2'd3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] expected_red;
      logic [SAMPLE_W-1:0] expected_green;
      logic [SAMPLE_W-1:0] expected_blue;
      logic [SAMPLE_W-1:0] estimated_red;
      logic [SAMPLE_W-1:0] estimated_green;
      logic [SAMPLE_W-1:0] estimated_blue;
      logic                last_pixel;
   } req_payload_type;

   typedef struct packed {
      logic [MSE_W-1:0]   mse;
      logic [COUNT_W-1:0] pixel_total;
      logic               overflow;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fmse_req_if.sv =====
// pixel-pair input channel: valid, ready and payload
// depends on fmse_pkg
`default_nettype none

interface fmse_req_if;
   import fmse_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fmse_rsp_if.sv =====
// result channel: valid, ready and payload
// depends on fmse_pkg
`default_nettype none

interface fmse_rsp_if;
   import fmse_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fmse_square_unit.sv =====
// shared absolute-difference and square unit, one channel per cycle
// depends on fmse_pkg
`default_nettype none

module fmse_square_unit (
   input  wire logic                     clock,
   input  wire fmse_pkg::req_payload_type pixel,
   input  wire logic [1:0]               chan_sel,
   output logic [fmse_pkg::PROD_W-1:0]   product
);
   import fmse_pkg::*;

   logic [SAMPLE_W-1:0] a_val;
   logic [SAMPLE_W-1:0] b_val;
   logic [SAMPLE_W-1:0] chan_delta;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   prod_in;

   always_comb begin
      case (chan_sel)
         CH_RED: begin
            a_val = pixel.expected_red;
            b_val = pixel.estimated_red;
         end
         CH_GREEN: begin
            a_val = pixel.expected_green;
            b_val = pixel.estimated_green;
         end
         CH_BLUE: begin
            a_val = pixel.expected_blue;
            b_val = pixel.estimated_blue;
         end
         default: begin
            // drain slot: zero square so nothing extra is summed
            a_val = '0;
            b_val = '0;
         end
      endcase
      a_val      = a_val & SAMPLE_MASK;
      b_val      = b_val & SAMPLE_MASK;
      chan_delta = (a_val >= b_val) ? (a_val - b_val) : (b_val - a_val);
      prod_in    = PROD_W'(chan_delta) * PROD_W'(chan_delta);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fmse_divider.sv =====
// restoring divider, one quotient bit per cycle, keeps low quotient bits
// depends on fmse_pkg
`default_nettype none

module fmse_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [fmse_pkg::SUM_W-1:0]  dividend,
   input  wire logic [fmse_pkg::DIV_W-1:0]  divisor,
   output logic                             done,
   output logic [fmse_pkg::MSE_W-1:0]       quotient
);
   import fmse_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   div_ff, div_in;
   logic [SUM_W-1:0]   dvd_ff, dvd_in;
   logic [MSE_W-1:0]   quot_ff, quot_in;
   logic [DIV_W:0]     trial;
   logic [DIV_W:0]     diff;
   logic               fits;

   always_comb begin
      trial   = {rem_ff, dvd_ff[SUM_W-1]};
      fits    = trial >= {1'b0, div_ff};
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      dvd_in  = dvd_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
         dvd_in  = dividend;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top trial bit drops out
         rem_in  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         dvd_in  = {dvd_ff[SUM_W-2:0], 1'b0};
         quot_in = {quot_ff[MSE_W-2:0], fits};
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/frame_mean_squared_error_top.sv =====
// Frame mean squared error. Each pixel pair transaction is accepted when the block is idle;
// the three channel squares then go through one shared difference-and-square unit, one channel
// a cycle, and are summed into a 56-bit accumulator. A pixel that arrives once the count has
// reached MAX_PIXELS is not summed. On the last pixel the sum is divided by three times the
// count in a restoring divider that produces one quotient bit per cycle; launch, 56 divide
// steps, a wait to see the divider finish and the result load then come before the result
// transaction is offered and the block is ready again. Results are held in an output register,
// so later pixels stream in while a result waits; the result load of the next frame waits
// until the previous result has been taken.
// depends on fmse_pkg, fmse_req_if, fmse_rsp_if, fmse_square_unit, fmse_divider
`default_nettype none

module frame_mean_squared_error_top (
   input  wire logic  clock,
   input  wire logic  reset,
   fmse_req_if.sink   req_chan,
   fmse_rsp_if.source rsp_chan
);
   import fmse_pkg::*;

   state_type          state_ff, state_in;
   logic [1:0]         step_ff, step_in;
   req_payload_type    pix_ff, pix_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   logic               out_free;
   logic               div_start;
   logic               div_done;
   logic [DIV_W-1:0]   divisor;
   logic [MSE_W-1:0]   quotient;
   logic [PROD_W-1:0]  product;
   logic [1:0]         chan_sel;

   fmse_square_unit u_square (
      .clock    (clock),
      .pixel    (pix_ff),
      .chan_sel (chan_sel),
      .product  (product)
   );

   assign divisor = {count_ff, 1'b0} + DIV_W'(count_ff);

   fmse_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      pix_in         = pix_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_in         = rsp_ff;
      req_chan.ready = 1'b0;
      div_start      = 1'b0;
      chan_sel       = CH_DRAIN;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               pix_in = req_chan.payload;
               if (count_ff >= MAX_COUNT) begin
                  ovf_in   = 1'b1;
                  state_in = req_chan.payload.last_pixel ? ST_LAUNCH : ST_IDLE;
               end else begin
                  count_in = count_ff + 1'b1;
                  step_in  = '0;
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            // channel n's square is registered and summed while channel n+1 is selected
            chan_sel = step_ff;
            if (step_ff != CH_RED) begin
               sum_in = sum_ff + SUM_W'(product);
            end
            step_in = step_ff + 1'b1;
            if (step_ff == CH_DRAIN) begin
               state_in = pix_ff.last_pixel ? ST_LAUNCH : ST_IDLE;
            end
         end
         ST_LAUNCH: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.mse         = quotient;
               rsp_in.pixel_total = count_ff;
               rsp_in.overflow    = ovf_ff;
               sum_in             = '0;
               count_in           = '0;
               ovf_in             = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_ff <= pix_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fmse_checker.sv =====
// port-level checks for the frame mse block, bound to the top level
// depends on fmse_pkg and frame_mean_squared_error_top_assert.svh
`default_nettype none

`include "frame_mean_squared_error_top_assert.svh"

module fmse_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire fmse_pkg::rsp_payload_type rsp_payload
);
   import fmse_pkg::*;

   logic req_accept;
   logic rsp_stall;

   assign req_accept = req_valid && req_ready;
   assign rsp_stall  = rsp_valid && !rsp_ready;

   // a stalled result transaction keeps its contents
   `FMSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // a pixel transaction accepted while no result is pending never brings out a result in the very next cycle
   `FMSE_ASSERT_NEXT(a_no_rsp_after_accept, clock, reset, req_accept && !rsp_valid, !rsp_valid)

   // a frame always counts its first pixel
   `FMSE_ASSERT_IMPLY(a_total_nonzero, clock, reset, rsp_valid, rsp_payload.pixel_total != '0)

   // overflow only once the count sits at its limit
   `FMSE_ASSERT_IMPLY(a_ovf_at_limit, clock, reset, rsp_valid && rsp_payload.overflow,
      rsp_payload.pixel_total == MAX_COUNT)

endmodule

bind frame_mean_squared_error_top fmse_checker u_fmse_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

`default_nettype wire

// ===== bench/tb_frame_mean_squared_error_top.sv =====
// self-checking bench for frame_mean_squared_error_top: directed and random pixel-pair frames against
// an in-bench mean squared error predictor, with random gaps and stalls on both channels
// depends on fmse_pkg, fmse_req_if, fmse_rsp_if and the top level
`timescale 1ns / 1ps

module tb_frame_mean_squared_error_top;
   import fmse_pkg::*;

   typedef enum int unsigned {PIX_RANDOM, PIX_EXTREME, PIX_NEAR} pixel_flavor_type;

   typedef struct {
      req_payload_type px;
      bit              drain_first;
   } pixel_job_type;

   logic clock = 1'b0;
   logic reset;

   fmse_req_if req_if ();
   fmse_rsp_if rsp_if ();

   frame_mean_squared_error_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #5 clock = ~clock;

   pixel_job_type   pending_pixels[$];
   rsp_payload_type expected_results[$];
   pixel_job_type   next_job;
   int unsigned     error_count = 0;
   int unsigned     pixels_queued = 0;

   // predictor state for the frame being accumulated
   logic [SUM_W-1:0]   square_total = '0;
   logic [COUNT_W-1:0] pixel_seen   = '0;
   logic               past_limit   = 1'b0;

   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;
   int unsigned req_gap = 0;
   int unsigned rsp_stall = 0;
   bit          req_steady = 1'b0;
   bit          rsp_steady = 1'b0;

   function automatic logic [PROD_W-1:0] channel_error(logic [SAMPLE_W-1:0] a,
                                                       logic [SAMPLE_W-1:0] b);
      logic [SAMPLE_W-1:0] x;
      logic [SAMPLE_W-1:0] y;
      logic [SAMPLE_W-1:0] d;
      x = a & SAMPLE_MASK;
      y = b & SAMPLE_MASK;
      d = (x >= y) ? x - y : y - x;
      return PROD_W'(d) * PROD_W'(d);
   endfunction

   task automatic accumulate_pixel(input req_payload_type px);
      rsp_payload_type outcome;
      logic [63:0]     divisor;
      if (pixel_seen >= MAX_PIXELS) begin
         past_limit = 1'b1;
      end else begin
         square_total = square_total
            + SUM_W'(channel_error(px.expected_red, px.estimated_red))
            + SUM_W'(channel_error(px.expected_green, px.estimated_green))
            + SUM_W'(channel_error(px.expected_blue, px.estimated_blue));
         pixel_seen = pixel_seen + 1'b1;
      end
      if (px.last_pixel) begin
         divisor = 64'(pixel_seen) * 64'd3;
         outcome.mse = (divisor != 0) ? MSE_W'(64'(square_total) / divisor) : '0;
         outcome.pixel_total = pixel_seen;
         outcome.overflow = past_limit;
         expected_results.push_back(outcome);
         square_total = '0;
         pixel_seen = '0;
         past_limit = 1'b0;
      end
   endtask

   task automatic check_frame_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_results.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("%0t: unexpected result mse=%h total=%0d overflow=%b",
                     $realtime, got.mse, got.pixel_total, got.overflow);
      end else begin
         want = expected_results.pop_front();
         if (got.mse !== want.mse || got.pixel_total !== want.pixel_total ||
             got.overflow !== want.overflow) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: mismatch (expected/actual) mse %h/%h total %0d/%0d ovf %b/%b",
                        $realtime, want.mse, got.mse, want.pixel_total, got.pixel_total,
                        want.overflow, got.overflow);
         end
      end
   endtask

   task automatic queue_pixel(input logic [SAMPLE_W-1:0] er, eg, eb, sr, sg, sb,
                              input bit last, input bit drain);
      pixel_job_type job;
      job.px.expected_red    = er;
      job.px.expected_green  = eg;
      job.px.expected_blue   = eb;
      job.px.estimated_red   = sr;
      job.px.estimated_green = sg;
      job.px.estimated_blue  = sb;
      job.px.last_pixel      = last;
      job.drain_first        = drain;
      pending_pixels.push_back(job);
      pixels_queued++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(pixel_flavor_type flavor,
                                                       logic [SAMPLE_W-1:0] partner);
      case (flavor)
         PIX_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
         PIX_NEAR:    return partner + SAMPLE_W'($urandom_range(0, 31)) - SAMPLE_W'(16);
         default:     return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic queue_random_frame(input int unsigned size, input bit drain);
      pixel_flavor_type           flavor;
      logic [SAMPLE_W-1:0]        er, eg, eb;
      flavor = pixel_flavor_type'($urandom_range(0, 2));
      for (int unsigned i = 0; i < size; i++) begin
         er = pick_sample(flavor == PIX_EXTREME ? PIX_EXTREME : PIX_RANDOM, '0);
         eg = pick_sample(flavor == PIX_EXTREME ? PIX_EXTREME : PIX_RANDOM, '0);
         eb = pick_sample(flavor == PIX_EXTREME ? PIX_EXTREME : PIX_RANDOM, '0);
         queue_pixel(er, eg, eb, pick_sample(flavor, er), pick_sample(flavor, eg),
                     pick_sample(flavor, eb), i == size - 1, drain && i == 0);
      end
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         rsp_taken <= rsp_if.valid && rsp_if.ready;
         if (req_if.valid && req_if.ready)
            accumulate_pixel(req_if.payload);
         if (rsp_if.valid && rsp_if.ready)
            check_frame_result(rsp_if.payload);
      end
   end

   // pixel transaction driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.payload <= '0;
      end else if (!req_if.valid || req_taken) begin
         if (req_taken) begin
            if ($urandom_range(0, 47) == 0)
               req_steady = !req_steady;
            req_gap = req_steady ? 0 : $urandom_range(0, 5);
         end
         if (req_gap != 0) begin
            req_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_pixels.size() != 0 &&
                      !(pending_pixels[0].drain_first && expected_results.size() != 0)) begin
            next_job = pending_pixels.pop_front();
            req_if.valid   <= 1'b1;
            req_if.payload <= next_job.px;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result side: hold off ready for a random stall once a result shows up, or keep it high in steady mode
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 7) == 0)
               rsp_steady = !rsp_steady;
            rsp_stall = $urandom_range(0, 5);
         end
         if (rsp_steady) begin
            rsp_if.ready <= 1'b1;
         end else if (rsp_if.valid && !rsp_taken && rsp_stall == 0) begin
            rsp_if.ready <= 1'b1;
         end else begin
            if (rsp_if.valid && !rsp_taken)
               rsp_stall--;
            rsp_if.ready <= 1'b0;
         end
      end
   end

   initial begin
      reset = 1'b1;

      // directed frames: zero error, full-scale error both ways, one channel at a time
      queue_pixel('0, '0, '0, '0, '0, '0, 1'b1, 1'b0);
      queue_pixel('1, '1, '1, '0, '0, '0, 1'b1, 1'b0);
      queue_pixel('0, '0, '0, '1, '1, '1, 1'b1, 1'b1);
      queue_pixel(16'hffff, 16'h1234, 16'h1234, 16'h0000, 16'h1234, 16'h1234, 1'b1, 1'b0);
      queue_pixel(16'h4321, 16'h8000, 16'h4321, 16'h4321, 16'h0000, 16'h4321, 1'b1, 1'b0);
      queue_pixel(16'h0001, 16'h0001, 16'h0000, 16'h0001, 16'h0001, 16'h0001, 1'b1, 1'b0);
      queue_pixel(16'h7abc, 16'h7abc, 16'h7abc, 16'h7abc, 16'h7abc, 16'h7abc, 1'b1, 1'b0);
      // alternating bit patterns, multi-pixel frame after a full drain
      queue_pixel(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 1'b0, 1'b1);
      queue_pixel(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1'b0, 1'b0);
      queue_pixel(16'hffff, 16'h0000, 16'h8000, 16'h7fff, 16'h0001, 16'hfffe, 1'b1, 1'b0);
      // truncation of the divide: 3 / 6 and 4 / 3
      queue_pixel(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
      queue_pixel(16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
      queue_pixel(16'h0002, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);

      // random frames, mostly short; the pixel limit lies far beyond this run
      while (pixels_queued < 1250) begin
         case ($urandom_range(0, 49))
            0:       queue_random_frame($urandom_range(60, 250), 1'b0);
            1, 2, 3: queue_random_frame($urandom_range(1, 6), 1'b1);
            default: begin
               if ($urandom_range(0, 3) == 0)
                  queue_random_frame($urandom_range(9, 40), 1'b0);
               else
                  queue_random_frame($urandom_range(1, 8), 1'b0);
            end
         endcase
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_pixels.size() != 0 || req_if.valid)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);

      if (error_count == 0 && expected_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fmse_pkg.sv
hw/rtl/fmse_req_if.sv
hw/rtl/fmse_rsp_if.sv
hw/rtl/fmse_square_unit.sv
hw/rtl/fmse_divider.sv
hw/rtl/frame_mean_squared_error_top.sv
hw/rtl/fmse_checker.sv
bench/tb_frame_mean_squared_error_top.sv
